FILE: hdl/sjsg_pkg.sv
package sjsg_pkg;

    localparam int JOINTS       = 6;
    localparam int PERIOD_MAX   = 20000;
    localparam int PERIOD_MIN   = 2;
    localparam int PERIOD_SCALE = 200000;
    localparam int WIN_LO_MS    = 100;
    localparam int WIN_HI_MS    = 200;
    localparam int COUNT_MAX    = 32767;
    localparam int SPEED_MAX    = 65535;
    localparam int SPEED_SCALE  = 100;

    localparam int JNT_W   = 3;
    localparam int POS_W   = 32;
    localparam int VEL_W   = 16;
    localparam int DT_W    = 16;
    localparam int PER_W   = 15;
    localparam int SPD_W   = 16;
    localparam int MASK_W  = 6;
    localparam int MAG_W   = POS_W + 1;
    localparam int NUM_W   = 40;
    localparam int SCALE_W = 18;
    localparam int CNT_W   = 6;

    localparam int IN_W   = 104;
    localparam int OUT_W  = 40;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_ROT = 1'b0;
    localparam logic REG_LIM = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_MAG  = 6'b000100,
        S_DIV  = 6'b001000,
        S_POST = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        OP_SPEED = 2'd0,
        OP_WANT  = 2'd1,
        OP_HAVE  = 2'd2
    } t_divop;

endpackage

FILE: hdl/stepper_joint_step_generator.sv
// flow: a tick, an update outside the time window or a joint out of range goes from input
// accept through evaluation to the output stage; an in-window update that keeps the period
// adds a magnitude step, a restoring divider pass for the speed and a post step; one that
// recomputes it adds two more divider passes, each with a post step; the next item is taken
// in the cycle after its result is loaded; a result held by m_axis_tready stalls S_OUT
// reset: synchronous active low, clears masks, per-joint state and output valid
module stepper_joint_step_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // joint[2:0], target_position[34:3], actual_position[66:35],
    // target_velocity[82:67], limit_active[83], elapsed_ms[99:84], zero pad
    input  logic [sjsg_pkg::IN_W-1:0]     s_axis_tdata,
    // command[0]
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // step_pulse[0], direction[1], at_target[2], blocked[3], velocity_error[4],
    // period_now[19:5], measured_speed[35:20], zero pad
    output logic [sjsg_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sjsg_pkg::ADDR_W-1:0]   paddr,
    input  logic [sjsg_pkg::DATA_W-1:0]   pwdata,
    output logic [sjsg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import sjsg_pkg::*;

    t_state                    r_state, n_state;
    t_divop                    r_op, n_op;
    logic [MASK_W-1:0]         r_rot, n_rot, r_lmask, n_lmask;
    logic [PER_W-1:0]          r_per [JOINTS], n_per [JOINTS];
    logic [PER_W-1:0]          r_tcnt [JOINTS], n_tcnt [JOINTS];
    logic                      r_zf [JOINTS], n_zf [JOINTS];
    logic [POS_W-1:0]          r_last [JOINTS], n_last [JOINTS];

    logic                      r_cmd, n_cmd;
    logic [JNT_W-1:0]          r_joint, n_joint;
    logic [POS_W-1:0]          r_tpos, n_tpos, r_apos, n_apos;
    logic [VEL_W-1:0]          r_tvel, n_tvel;
    logic                      r_lim, n_lim;
    logic [DT_W-1:0]           r_dt, n_dt;

    logic                      r_step, n_step, r_blk, n_blk;
    logic [SPD_W-1:0]          r_speed, n_speed;
    logic [MAG_W-1:0]          r_mag, n_mag;
    logic [NUM_W-1:0]          r_num, n_num;
    logic [SPD_W-1:0]          r_rem, n_rem, r_den, n_den;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [SCALE_W-1:0]        r_want, n_want;

    logic                      r_mvalid, n_mvalid;
    logic [OUT_W-1:0]          r_mdata, n_mdata;

    logic                      w_gt;
    logic                      w_at, w_jv, w_dir;
    logic [JNT_W-1:0]          w_j;

    assign w_j     = r_joint;
    assign w_jv    = r_joint < JNT_W'(JOINTS);
    assign w_gt    = signed'(r_tpos) > signed'(r_apos);
    assign w_at    = r_tpos == r_apos;
    assign w_dir   = w_jv && !w_at && (w_gt ^ r_rot[w_j]);

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_LIM) ? DATA_W'(r_lmask) : DATA_W'(r_rot);

    always_comb begin
        logic [PER_W-1:0]    cnt1;
        logic [MAG_W:0]      diff;
        logic [SPD_W:0]      shifted;
        logic                ge;
        logic [SPD_W-1:0]    sat;
        logic signed [PER_W+1:0] np;

        n_state  = r_state;
        n_op     = r_op;
        n_rot    = r_rot;
        n_lmask  = r_lmask;
        n_per    = r_per;
        n_tcnt   = r_tcnt;
        n_zf     = r_zf;
        n_last   = r_last;
        n_cmd    = r_cmd;
        n_joint  = r_joint;
        n_tpos   = r_tpos;
        n_apos   = r_apos;
        n_tvel   = r_tvel;
        n_lim    = r_lim;
        n_dt     = r_dt;
        n_step   = r_step;
        n_blk    = r_blk;
        n_speed  = r_speed;
        n_mag    = r_mag;
        n_num    = r_num;
        n_rem    = r_rem;
        n_den    = r_den;
        n_cnt    = r_cnt;
        n_want   = r_want;
        n_mvalid = r_mvalid;
        n_mdata  = r_mdata;
        cnt1     = '0;
        diff     = '0;
        shifted  = '0;
        ge       = 1'b0;
        sat      = '0;
        np       = '0;

        if (psel && penable && pwrite) begin
            if (paddr[2] == REG_LIM) begin
                n_lmask = pwdata[MASK_W-1:0];
            end else begin
                n_rot = pwdata[MASK_W-1:0];
            end
        end

        if (r_mvalid && m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tuser[0];
                    n_joint = s_axis_tdata[2:0];
                    n_tpos  = s_axis_tdata[34:3];
                    n_apos  = s_axis_tdata[66:35];
                    n_tvel  = s_axis_tdata[82:67];
                    n_lim   = s_axis_tdata[83];
                    n_dt    = s_axis_tdata[99:84];
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_step  = 1'b0;
                n_blk   = 1'b0;
                n_speed = '0;
                n_state = S_OUT;
                if (w_jv) begin
                    if (!r_cmd) begin
                        if (!w_at) begin
                            if (r_lim && (w_dir == r_lmask[w_j])) begin
                                n_blk = 1'b1;
                            end else begin
                                cnt1 = (r_tcnt[w_j] < PER_W'(COUNT_MAX)) ?
                                       r_tcnt[w_j] + 1'b1 : r_tcnt[w_j];
                                if (!r_zf[w_j] && cnt1 >= r_per[w_j]) begin
                                    n_tcnt[w_j] = '0;
                                    n_step      = 1'b1;
                                end else begin
                                    n_tcnt[w_j] = cnt1;
                                end
                            end
                        end
                    end else if (r_dt >= DT_W'(WIN_LO_MS) && r_dt <= DT_W'(WIN_HI_MS)) begin
                        diff    = {{2{r_apos[POS_W-1]}}, r_apos}
                                - {{2{r_last[w_j][POS_W-1]}}, r_last[w_j]};
                        n_mag   = diff[MAG_W] ? MAG_W'(~diff + 1'b1) : diff[MAG_W-1:0];
                        n_state = S_MAG;
                    end
                end
            end
            S_MAG: begin
                n_num   = NUM_W'(r_mag) * NUM_W'(SPEED_SCALE);
                n_rem   = '0;
                n_den   = r_dt;
                n_cnt   = CNT_W'(NUM_W);
                n_op    = OP_SPEED;
                n_state = S_DIV;
            end
            S_DIV: begin
                shifted = {r_rem, r_num[NUM_W-1]};
                ge      = shifted >= {1'b0, r_den};
                n_rem   = ge ? SPD_W'(shifted - {1'b0, r_den}) : shifted[SPD_W-1:0];
                n_num   = {r_num[NUM_W-2:0], ge};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_state = S_OUT;
                case (r_op)
                    OP_SPEED: begin
                        sat     = (r_num > NUM_W'(SPEED_MAX)) ? SPD_W'(SPEED_MAX)
                                                              : r_num[SPD_W-1:0];
                        n_speed = sat;
                        if (!w_at) begin
                            n_zf[w_j] = r_tvel == '0;
                            if (r_tvel != '0) begin
                                if (sat == '0) begin
                                    n_per[w_j] = PER_W'(PERIOD_MAX);
                                end else begin
                                    n_num   = NUM_W'(PERIOD_SCALE) << (NUM_W - SCALE_W);
                                    n_rem   = '0;
                                    n_den   = r_tvel;
                                    n_cnt   = CNT_W'(SCALE_W);
                                    n_op    = OP_WANT;
                                    n_state = S_DIV;
                                end
                            end
                        end
                    end
                    OP_WANT: begin
                        n_want  = r_num[SCALE_W-1:0];
                        n_num   = NUM_W'(PERIOD_SCALE) << (NUM_W - SCALE_W);
                        n_rem   = '0;
                        n_den   = r_speed;
                        n_cnt   = CNT_W'(SCALE_W);
                        n_op    = OP_HAVE;
                        n_state = S_DIV;
                    end
                    OP_HAVE: begin
                        np = signed'({2'b00, r_per[w_j]});
                        if (r_want > r_num[SCALE_W-1:0]) begin
                            np = np + signed'((PER_W+2)'(1));
                        end else if (r_want < r_num[SCALE_W-1:0]) begin
                            np = np - signed'((PER_W+2)'(1));
                        end
                        if (np < signed'((PER_W+2)'(PERIOD_MIN))) begin
                            np = signed'((PER_W+2)'(PERIOD_MIN));
                        end
                        if (np > signed'((PER_W+2)'(PERIOD_MAX))) begin
                            np = signed'((PER_W+2)'(PERIOD_MAX));
                        end
                        n_per[w_j]  = np[PER_W-1:0];
                        n_last[w_j] = r_apos;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_mvalid = 1'b1;
                    if (w_jv) begin
                        n_mdata = OUT_W'({r_speed, r_per[w_j], r_zf[w_j],
                                          r_blk, w_at, w_dir, r_step});
                    end else begin
                        n_mdata = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mvalid <= 1'b0;
            r_rot    <= '0;
            r_lmask  <= '0;
            for (int k = 0; k < JOINTS; k++) begin
                r_per[k]  <= '0;
                r_tcnt[k] <= '0;
                r_zf[k]   <= 1'b0;
                r_last[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_mvalid <= n_mvalid;
            r_rot    <= n_rot;
            r_lmask  <= n_lmask;
            r_per    <= n_per;
            r_tcnt   <= n_tcnt;
            r_zf     <= n_zf;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_cmd   <= n_cmd;
        r_joint <= n_joint;
        r_tpos  <= n_tpos;
        r_apos  <= n_apos;
        r_tvel  <= n_tvel;
        r_lim   <= n_lim;
        r_dt    <= n_dt;
        r_step  <= n_step;
        r_blk   <= n_blk;
        r_speed <= n_speed;
        r_mag   <= n_mag;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_cnt   <= n_cnt;
        r_want  <= n_want;
        r_mdata <= n_mdata;
    end

endmodule
